// File: rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants for the closest departure search block.
// ----------------------------------------------------------------------------
package cds_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Time encoding: minutes of the day, hour * 60 + minute
   localparam int HOUR_W       = 5;
   localparam int MIN_W        = 6;
   localparam int TIME_W       = 11;
   localparam int ENTRY_W      = 2 * TIME_W;
   localparam int MIN_PER_HOUR = 60;

   // Divide by 60 through a slightly low reciprocal, corrected by one step
   localparam int RECIP_W   = 11;
   localparam int DIV_RECIP = 1092;
   localparam int DIV_SHIFT = 16;
   localparam int PROD_W    = TIME_W + RECIP_W;
   localparam int EST_W     = PROD_W - DIV_SHIFT;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_FIX
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [HOUR_W-1:0]   depart_hour;
      logic [MIN_W-1:0]    dep_minute;
      logic [HOUR_W-1:0]   arrive_hour;
      logic [MIN_W-1:0]    arr_minute;
      logic [HOUR_W-1:0]   query_hour;
      logic [MIN_W-1:0]    query_minute;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [HOUR_W-1:0]   out_dep_hour;
      logic [MIN_W-1:0]    out_dep_minute;
      logic [HOUR_W-1:0]   out_arr_hour;
      logic [MIN_W-1:0]    out_arr_minute;
      logic                overflowed;
   } rsp_type;

   // Convert hour and minute fields to minutes of the day (60 = 64 - 4)
   function automatic logic [TIME_W-1:0] to_minutes(
      input logic [HOUR_W-1:0] hour,
      input logic [MIN_W-1:0]  minute
   );
      logic [TIME_W-1:0] h64;
      logic [TIME_W-1:0] h4;
      h64 = TIME_W'({hour, 6'b0});
      h4  = TIME_W'({hour, 2'b0});
      return h64 - h4 + TIME_W'(minute);
   endfunction

endpackage

// File: rtl/closest_departure_search.sv
// ----------------------------------------------------------------------------
// closest_departure_search
// Flight table with a nearest-departure query over the stored entries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with a req_type payload. A clear
//   request empties the table, a load request appends one flight, and a
//   query request returns the flight whose departure lies nearest the query
//   time (ties to the earlier departure, then the earlier arrival).
//   Only queries produce a response on rsp_valid/rsp_ready.
//   Clear and load complete without leaving idle. A query scans the stored
//   entries, reading the table RAM one entry per cycle, then converts the
//   best flight back to hours and minutes in ST_DIV and ST_FIX; an empty
//   table skips the scan.
//   The block holds one request at a time; req_ready is high while idle.
//   A finished response waits in an output register, so the next request
//   is taken while the receiver stalls. A query that finishes while the
//   previous response is still unread waits until that one is taken.
//   Reset empties the table, clears the overflow flag and drops any
//   pending response. The table RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module closest_departure_search
   import cds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [TIME_W-1:0] query_ff, query_in;
   logic              any_ff, any_in;
   logic [TIME_W-1:0] best_dep_ff, best_dep_in;
   logic [TIME_W-1:0] best_arr_ff, best_arr_in;
   logic [TIME_W-1:0] best_dist_ff, best_dist_in;
   logic [EST_W-1:0]  dep_est_ff, dep_est_in;
   logic [EST_W-1:0]  arr_est_ff, arr_est_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic [TIME_W-1:0]  ent_dep;
   logic [TIME_W-1:0]  ent_arr;
   logic [TIME_W-1:0]  gap;
   logic               better;
   logic [PROD_W-1:0]  dep_prod;
   logic [PROD_W-1:0]  arr_prod;
   logic [TIME_W-1:0]  dep_rem;
   logic [TIME_W-1:0]  arr_rem;
   logic [EST_W-1:0]   dep_hr;
   logic [EST_W-1:0]   arr_hr;
   logic [TIME_W-1:0]  dep_mn;
   logic [TIME_W-1:0]  arr_mn;

   // Flight table: arrival in the upper half, departure in the lower half
   cds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Compare the entry read last cycle against the running best
   assign ent_dep = rd_data[TIME_W-1:0];
   assign ent_arr = rd_data[ENTRY_W-1:TIME_W];
   assign gap     = (query_ff > ent_dep) ? (query_ff - ent_dep) : (ent_dep - query_ff);

   always_comb begin
      if (!any_ff) begin
         better = 1'b1;
      end else if (gap != best_dist_ff) begin
         better = gap < best_dist_ff;
      end else if (ent_dep != best_dep_ff) begin
         better = ent_dep < best_dep_ff;
      end else begin
         better = ent_arr < best_arr_ff;
      end
   end

   // Hour estimate from the reciprocal, at most one below the true hour
   assign dep_prod = PROD_W'(best_dep_ff) * PROD_W'(DIV_RECIP);
   assign arr_prod = PROD_W'(best_arr_ff) * PROD_W'(DIV_RECIP);

   // Remainder and one-step correction of the estimate
   assign dep_rem = best_dep_ff - TIME_W'({dep_est_ff, 6'b0}) + TIME_W'({dep_est_ff, 2'b0});
   assign arr_rem = best_arr_ff - TIME_W'({arr_est_ff, 6'b0}) + TIME_W'({arr_est_ff, 2'b0});

   always_comb begin
      if (dep_rem >= TIME_W'(MIN_PER_HOUR)) begin
         dep_hr = dep_est_ff + EST_W'(1);
         dep_mn = dep_rem - TIME_W'(MIN_PER_HOUR);
      end else begin
         dep_hr = dep_est_ff;
         dep_mn = dep_rem;
      end
      if (arr_rem >= TIME_W'(MIN_PER_HOUR)) begin
         arr_hr = arr_est_ff + EST_W'(1);
         arr_mn = arr_rem - TIME_W'(MIN_PER_HOUR);
      end else begin
         arr_hr = arr_est_ff;
         arr_mn = arr_rem;
      end
   end

   // Sequencer: next state, table access and response register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      query_in     = query_ff;
      any_in       = any_ff;
      best_dep_in  = best_dep_ff;
      best_arr_in  = best_arr_ff;
      best_dist_in = best_dist_ff;
      dep_est_in   = dep_est_ff;
      arr_est_in   = arr_est_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = {to_minutes(req_data.arrive_hour, req_data.arr_minute),
                      to_minutes(req_data.depart_hour, req_data.dep_minute)};
      rd_en        = 1'b0;
      rd_addr      = issue_ff[ADDR_W-1:0];

      // Drop the response once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LOAD: begin
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     query_in     = to_minutes(req_data.query_hour, req_data.query_minute);
                     any_in       = 1'b0;
                     best_dep_in  = '0;
                     best_arr_in  = '0;
                     best_dist_in = '0;
                     if (count_ff == '0) begin
                        state_in = ST_DIV;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        issue_in = CNT_W'(1);
                        pend_in  = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Fold in the entry that arrived, issue the next read
            if (pend_ff && better) begin
               any_in       = 1'b1;
               best_dep_in  = ent_dep;
               best_arr_in  = ent_arr;
               best_dist_in = gap;
            end
            if (issue_ff < count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end else begin
               pend_in  = 1'b0;
            end
            if (!pend_ff) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dep_est_in = dep_prod[PROD_W-1:DIV_SHIFT];
            arr_est_in = arr_prod[PROD_W-1:DIV_SHIFT];
            state_in   = ST_FIX;
         end
         ST_FIX: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.found          = any_ff;
               rsp_data_in.out_dep_hour   = dep_hr[HOUR_W-1:0];
               rsp_data_in.out_dep_minute = dep_mn[MIN_W-1:0];
               rsp_data_in.out_arr_hour   = arr_hr[HOUR_W-1:0];
               rsp_data_in.out_arr_minute = arr_mn[MIN_W-1:0];
               rsp_data_in.overflowed     = ovf_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      best_dep_ff  <= best_dep_in;
      best_arr_ff  <= best_arr_in;
      best_dist_ff <= best_dist_in;
      dep_est_ff   <= dep_est_in;
      arr_est_ff   <= arr_est_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// File: rtl/cds_ram.sv
// ----------------------------------------------------------------------------
// cds_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cds_checker.sv
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks for the closest departure search block, bound to the top.
// ----------------------------------------------------------------------------
module cds_checker
   import cds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data
);

   logic seen_ovf_ff;

   // Remember that a response has reported an overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ovf_ff <= 1'b0;
      end else if (rsp_valid && rsp_data.overflowed) begin
         seen_ovf_ff <= 1'b1;
      end
   end

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.out_dep_hour == '0 && rsp_data.out_dep_minute == '0 &&
         rsp_data.out_arr_hour == '0 && rsp_data.out_arr_minute == '0)
      else $error("empty-table response carries a flight");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_QUERY |=> !req_ready)
      else $error("request taken while a query is in progress");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ovf_ff |-> rsp_data.overflowed)
      else $error("overflow flag cleared without reset");

endmodule

bind closest_departure_search cds_checker u_cds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
